FILE: src/dsld_pkg.sv
package dsld_pkg;

    localparam logic [7:0] LEAD_RST  = 8'hAA;
    localparam logic [7:0] START_RST = 8'hBB;
    localparam logic [7:0] END_RST   = 8'hCC;

    // config register indexes
    localparam logic [1:0] REG_LEAD  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    typedef enum logic [7:0] {
        PH_HUNT      = 8'b0000_0001,
        PH_START     = 8'b0000_0010,
        PH_LEN_HI    = 8'b0000_0100,
        PH_LEN_LO    = 8'b0000_1000,
        PH_PAYLOAD   = 8'b0001_0000,
        PH_LRC       = 8'b0010_0000,
        PH_TRAIL_LD  = 8'b0100_0000,
        PH_TRAIL_END = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADLRC = 2'd2,
        KIND_BADTRL = 2'd3
    } t_kind;

    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] frame_length;
    } t_result;

    // handshake between the parser and the output buffer
    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

endpackage

FILE: src/dsld_if.sv
interface dsld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dsld_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] frame_length;

    modport source (output valid, output kind, output data, output frame_length,
                    input ready);
    modport sink   (input valid, input kind, input data, input frame_length,
                    output ready);
endinterface

FILE: src/dsld_core.sv
module dsld_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsld_pkg::t_cfg_wr i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    input  logic              i_space,
    output dsld_pkg::t_push   o_push
);
    import dsld_pkg::*;

    logic [7:0]  r_lead, r_start, r_end;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    t_phase      r_phase, n_phase;
    logic [15:0] r_payload_len, n_payload_len;
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic [7:0]  r_xor, n_xor;
    logic        r_mismatch, n_mismatch;
    logic        adv;
    logic [15:0] seen_inc;

    // byte in the input register is consumed when the buffer has room
    assign adv     = r_in_vld && i_space;
    assign o_ready = !r_in_vld || i_space;
    assign seen_inc = r_bytes_seen + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= LEAD_RST;
            r_start <= START_RST;
            r_end   <= END_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_LEAD:  r_lead  <= i_cfg.wdata;
                REG_START: r_start <= i_cfg.wdata;
                REG_END:   r_end   <= i_cfg.wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_payload_len = r_payload_len;
        n_bytes_seen  = r_bytes_seen;
        n_xor         = r_xor;
        n_mismatch    = r_mismatch;
        o_push.push              = 1'b0;
        o_push.res.kind          = KIND_DATA;
        o_push.res.data          = 8'd0;
        o_push.res.frame_length  = r_payload_len;
        if (adv) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_in_byte == r_lead) n_phase = PH_START;
                end
                PH_START: begin
                    if (r_in_byte == r_start)     n_phase = PH_LEN_HI;
                    else if (r_in_byte != r_lead) n_phase = PH_HUNT;
                end
                PH_LEN_HI: begin
                    n_payload_len = {r_in_byte, 8'd0};
                    n_phase       = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_payload_len = {r_payload_len[15:8], r_in_byte};
                    n_bytes_seen  = 16'd0;
                    n_xor         = 8'd0;
                    n_mismatch    = 1'b0;
                    n_phase = (n_payload_len == 16'd0) ? PH_LRC : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_xor        = r_xor ^ r_in_byte;
                    n_bytes_seen = seen_inc;
                    if (seen_inc == r_payload_len) n_phase = PH_LRC;
                    o_push.push     = 1'b1;
                    o_push.res.data = r_in_byte;
                end
                PH_LRC: begin
                    n_mismatch = (r_in_byte != r_xor);
                    n_phase    = PH_TRAIL_LD;
                end
                PH_TRAIL_LD: begin
                    if (r_in_byte == r_lead) begin
                        n_phase = PH_TRAIL_END;
                    end else begin
                        n_phase         = PH_HUNT;
                        o_push.push     = 1'b1;
                        o_push.res.kind = KIND_BADTRL;
                    end
                end
                PH_TRAIL_END: begin
                    o_push.push = 1'b1;
                    if (r_in_byte == r_end) begin
                        n_phase         = PH_HUNT;
                        o_push.res.kind = r_mismatch ? KIND_BADLRC : KIND_GOOD;
                    end else begin
                        // a bad end byte equal to lead opens the next frame
                        n_phase = (r_in_byte == r_lead) ? PH_START : PH_HUNT;
                        o_push.res.kind = KIND_BADTRL;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_payload_len <= 16'd0;
            r_bytes_seen  <= 16'd0;
            r_xor         <= 8'd0;
            r_mismatch    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_payload_len <= n_payload_len;
            r_bytes_seen  <= n_bytes_seen;
            r_xor         <= n_xor;
            r_mismatch    <= n_mismatch;
        end
    end

`ifndef SYNTHESIS
    a_good_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.push && o_push.res.kind == KIND_GOOD) |=> r_phase == PH_HUNT)
        else $error("good verdict did not return to hunt");
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_seen < r_payload_len)
        else $error("payload count overran length");
    a_lrc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LRC && $past(r_phase) == PH_PAYLOAD)
        |-> r_bytes_seen == r_payload_len)
        else $error("left payload before length reached");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push |-> i_space)
        else $error("result pushed into full buffer");
`endif
endmodule

FILE: src/dsld_obuf.sv
module dsld_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsld_pkg::t_push   i_push,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output dsld_pkg::t_result o_res
);
    import dsld_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)         r_rd_ptr <= ~r_rd_ptr;
            if (i_push.push && !pop)      r_count <= r_count + 2'd1;
            else if (!i_push.push && pop) r_count <= r_count - 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("buffer count out of range");
    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push && pop) |=> $stable(r_count))
        else $error("count moved on push with pop");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("pointers disagree with count");
`endif
endmodule

FILE: src/dle_stx_lrc_deframer_unit.sv
// Lead/start framed byte stream deframer with XOR LRC check.
// i_rx (sink): one received link byte per beat. o_res (source): one result
// beat per payload byte (kind = data) and one verdict beat per frame end
// (good, LRC mismatch, or bad trailer), frame_length from the header.
// Header, length and LRC bytes and hunt bytes produce no result beat.
// Config: write i_cfg_we with i_cfg_idx (0 lead, 1 start, 2 end byte) and
// i_cfg_wdata; write only while no bytes are in flight. Index 3 is ignored.
// A byte accepted from i_rx lands in the input register; once the output buffer
// has a free slot it is parsed and pushed into the 2-entry output buffer, and its
// result beat is then visible on o_res. Throughput is one byte per clock,
// limited only by the output buffer having a free slot.
// Downstream stall: the buffer fills with up to two result beats; once it is
// full the byte in the input register waits and i_rx.ready drops; no beat is
// lost or repeated.
// Reset (i_rst_n low, synchronous): frame state back to hunting, LRC and
// counters cleared, config registers to 0xAA/0xBB/0xCC, buffers emptied.
// Payload of a frame whose verdict is not good is to be dropped by the user.
module dle_stx_lrc_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsld_rx_if.sink    i_rx,
    dsld_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);
    import dsld_pkg::*;

    t_cfg_wr cfg;
    t_push   push;
    t_result res;
    logic    space;

    assign cfg.we    = i_cfg_we;
    assign cfg.idx   = i_cfg_idx;
    assign cfg.wdata = i_cfg_wdata;

    dsld_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_space (space),
        .o_push  (push)
    );

    dsld_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    // verdict beats carry zero data by construction in the parser
    assign o_res.kind         = res.kind;
    assign o_res.data         = res.data;
    assign o_res.frame_length = res.frame_length;

endmodule

FILE: sim/dle_stx_lrc_deframer_unit_tb.sv
module dle_stx_lrc_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsld_pkg::*;

    // index 3 has no register behind it, writes to it must be dropped
    localparam logic [1:0] REG_NONE = 2'd3;

    // bytes of random stimulus per framing setting
    localparam int PHASE_BYTES = 115;
    localparam int N_PHASES    = 5;
    // cycles the block may still chew on a byte after the last result beat
    localparam int TAIL_CYCLES = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_wdata;

    dsld_rx_if  rx_if ();
    dsld_res_if res_if ();

    dle_stx_lrc_deframer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the deframer: framing bytes and frame state
    // ------------------------------------------------------------------
    logic [7:0]  lead_sh  = LEAD_RST;
    logic [7:0]  start_sh = START_RST;
    logic [7:0]  end_sh   = END_RST;

    t_phase      frm_ph   = PH_HUNT;
    logic [15:0] hdr_len  = '0;    // length from header
    logic [15:0] seen_cnt = '0;    // payload bytes taken so far
    logic [7:0]  lrc_acc  = '0;    // xor of payload so far
    bit          lrc_bad  = 1'b0;  // LRC byte did not match

    // results still owed by the block, oldest first
    t_result     pending_res[$];

    int err_cnt    = 0;
    int n_bytes    = 0;
    int n_beats    = 0;
    int n_good     = 0;
    int n_lrc      = 0;
    int n_trl      = 0;
    int n_settings = 0;

    bit quiet    = 1'b0;   // no idling on either side while set
    int hold_req = 0;      // long receiver hold-off, picked up by the receiver

    // Walk one byte through the frame state. hit says whether a result beat
    // comes out of it.
    task automatic deframe_track(input logic [7:0] b, output bit hit, output t_result res);
        hit = 1'b0;
        res = '0;
        case (frm_ph)
            PH_HUNT: begin
                if (b == lead_sh) frm_ph = PH_START;
            end
            PH_START: begin
                // repeated lead keeps waiting for the start byte
                if (b == start_sh)     frm_ph = PH_LEN_HI;
                else if (b != lead_sh) frm_ph = PH_HUNT;
            end
            PH_LEN_HI: begin
                hdr_len = {b, 8'h00};
                frm_ph  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_len[7:0] = b;
                seen_cnt     = '0;
                lrc_acc      = '0;
                lrc_bad      = 1'b0;
                // zero length goes straight to the LRC byte
                frm_ph = (hdr_len == 16'd0) ? PH_LRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                lrc_acc  = lrc_acc ^ b;
                seen_cnt = seen_cnt + 16'd1;
                if (seen_cnt == hdr_len) frm_ph = PH_LRC;
                hit      = 1'b1;
                res.kind = KIND_DATA;
                res.data = b;
            end
            PH_LRC: begin
                lrc_bad = (b != lrc_acc);
                frm_ph  = PH_TRAIL_LD;
            end
            PH_TRAIL_LD: begin
                if (b == lead_sh) begin
                    frm_ph = PH_TRAIL_END;
                end else begin
                    // bad first trailer byte: verdict now, byte is not rescanned
                    frm_ph   = PH_HUNT;
                    hit      = 1'b1;
                    res.kind = KIND_BADTRL;
                end
            end
            PH_TRAIL_END: begin
                hit = 1'b1;
                if (b == end_sh) begin
                    frm_ph   = PH_HUNT;
                    res.kind = lrc_bad ? KIND_BADLRC : KIND_GOOD;
                end else begin
                    // bad trailer wins over bad LRC; a lead here opens a new frame
                    frm_ph   = (b == lead_sh) ? PH_START : PH_HUNT;
                    res.kind = KIND_BADTRL;
                end
            end
            default: frm_ph = PH_HUNT;
        endcase
        res.frame_length = hdr_len;
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one byte, hold it until the beat is taken, then track it.
    task automatic offer_byte(input logic [7:0] b, output bit hit, output t_result res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        n_bytes++;
        deframe_track(b, hit, res);
    endtask

    task automatic send_byte(input logic [7:0] b);
        bit      hit;
        t_result res;
        offer_byte(b, hit, res);
        if (hit) pending_res.insert(pending_res.size(), res);
    endtask

    // Stop offering, let every owed beat come out, then give the block
    // a few cycles for bytes that make no beat.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write all framing registers plus the unused index, one per cycle.
    task automatic set_framing(input logic [7:0] l, input logic [7:0] s,
                               input logic [7:0] e, input logic [7:0] junk);
        logic [1:0] idx;
        logic [7:0] val;
        for (int i = 0; i < 4; i++) begin
            case (i)
                0:       begin idx = REG_LEAD;  val = l;    end
                1:       begin idx = REG_START; val = s;    end
                2:       begin idx = REG_END;   val = e;    end
                default: begin idx = REG_NONE;  val = junk; end
            endcase
            cfg_we    <= 1'b1;
            cfg_idx   <= idx;
            cfg_wdata <= val;
            @(posedge i_clk);
            case (idx)
                REG_LEAD:  lead_sh  = val;
                REG_START: start_sh = val;
                REG_END:   end_sh   = val;
                default:   ;
            endcase
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Up to two noise bytes, then one frame of the given length. Most frames
    // are clean; the rest carry a bad LRC, a bad trailer, or a broken header.
    task automatic send_frame(input logic [15:0] len);
        int         c;
        int         k;
        logic [7:0] lrc;
        logic [7:0] b;
        logic [7:0] flip;

        k = $urandom_range(0, 2);
        for (int i = 0; i < k; i++) begin
            b = ($urandom_range(0, 9) == 0) ? lead_sh : 8'($urandom_range(0, 255));
            send_byte(b);
        end

        c = $urandom_range(0, 99);
        send_byte(lead_sh);
        if (c >= 95) begin
            // lead followed by junk instead of the start byte
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_byte(start_sh);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        lrc = '0;
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            lrc = lrc ^ b;
            send_byte(b);
        end
        if (c >= 65 && c < 77) begin
            flip = 8'($urandom_range(1, 255));
            lrc  = lrc ^ flip;
        end else if (c >= 85 && $urandom_range(0, 1) == 1) begin
            flip = 8'($urandom_range(1, 255));
            lrc  = lrc ^ flip;   // bad trailer on top of bad LRC
        end
        send_byte(lrc);
        if (c >= 77 && c < 85) begin
            // first trailer byte wrong
            do b = 8'($urandom_range(0, 255)); while (b == lead_sh);
            send_byte(b);
        end else begin
            send_byte(lead_sh);
            if (c >= 85) begin
                // second trailer byte wrong, half the time a fresh lead
                if ($urandom_range(0, 1) == 1) begin
                    b = lead_sh;
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == end_sh);
                end
                send_byte(b);
            end else begin
                send_byte(end_sh);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: byte, and where obvious the beat it must produce
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        bit         chk;
        t_result    want;
    } t_dir_row;

    t_dir_row dir_tab[$];

    task automatic tab_plain(input logic [7:0] b);
        t_dir_row r;
        r.b    = b;
        r.chk  = 1'b0;
        r.want = '0;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic tab_typed(input logic [7:0] b, input t_kind k, input logic [7:0] d,
                             input logic [15:0] n);
        t_dir_row r;
        r.b                 = b;
        r.chk               = 1'b1;
        r.want.kind         = k;
        r.want.data         = d;
        r.want.frame_length = n;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin
        bit         hit;
        t_result    res;
        logic [7:0] l;
        logic [7:0] s;
        logic [7:0] e;
        int         r;
        int         mark;
        logic [15:0] len;

        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= REG_LEAD;
        cfg_wdata     <= 8'h00;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;

        // reset framing AA/BB/CC
        // zero length, repeated lead before start, good
        tab_plain(8'hAA);
        tab_plain(8'hAA);
        tab_plain(8'hBB);
        tab_plain(8'h00);
        tab_plain(8'h00);
        tab_plain(8'h00);
        tab_plain(8'hAA);
        tab_typed(8'hCC, KIND_GOOD, 8'h00, 16'd0);
        // one payload byte, LRC wrong
        tab_plain(8'hAA);
        tab_plain(8'hBB);
        tab_plain(8'h00);
        tab_plain(8'h01);
        tab_typed(8'hFF, KIND_DATA, 8'hFF, 16'd1);
        tab_plain(8'h00);
        tab_plain(8'hAA);
        tab_typed(8'hCC, KIND_BADLRC, 8'h00, 16'd1);
        // bad LRC and bad second trailer byte that is a lead: new frame open
        tab_plain(8'hAA);
        tab_plain(8'hBB);
        tab_plain(8'h00);
        tab_plain(8'h00);
        tab_plain(8'h5A);
        tab_plain(8'hAA);
        tab_typed(8'hAA, KIND_BADTRL, 8'h00, 16'd0);
        // start byte right away, zero length, bad first trailer byte
        tab_plain(8'hBB);
        tab_plain(8'h00);
        tab_plain(8'h00);
        tab_plain(8'h00);
        tab_typed(8'h00, KIND_BADTRL, 8'h00, 16'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            offer_byte(dir_tab[i].b, hit, res);
            if (hit) begin
                if (dir_tab[i].chk) pending_res.insert(pending_res.size(), dir_tab[i].want);
                else                pending_res.insert(pending_res.size(), res);
            end else if (dir_tab[i].chk) begin
                err_cnt++;
                $display("directed row %0d: no beat predicted for byte %02h",
                         i, dir_tab[i].b);
            end
        end

        // random frames under several framing settings, extremes first
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: set_framing(8'h00, 8'hFF, 8'h00, 8'h55);
                1: set_framing(8'hFF, 8'h00, 8'hFF, 8'hAA);
                4: set_framing(LEAD_RST, START_RST, END_RST, 8'($urandom_range(0, 255)));
                default: begin
                    l = 8'($urandom_range(0, 255));
                    s = 8'($urandom_range(0, 255));
                    e = 8'($urandom_range(0, 255));
                    set_framing(l, s, e, 8'($urandom_range(0, 255)));
                end
            endcase
            // receiver goes away for a long stretch while bytes keep coming
            if (p == 1) hold_req = 250;
            // one phase runs flat out on both sides
            quiet = (p == 3);
            mark  = n_bytes;
            while (n_bytes - mark < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = 16'($urandom_range(0, 8));
                else if (r < 98) len = 16'($urandom_range(9, 40));
                else             len = 16'($urandom_range(200, 300));
                send_frame(len);
            end
            quiet = 1'b0;
        end

        settle();
        repeat (8) @(posedge i_clk);

        $display("%0d link bytes in %0d framing settings, %0d result beats checked",
                 n_bytes, n_settings, n_beats);
        $display("verdicts: %0d good, %0d lrc mismatch, %0d bad trailer",
                 n_good, n_lrc, n_trl);
        if (err_cnt == 0 && pending_res.size() == 0) begin
            $display("dle_stx_lrc_deframer_unit_tb: clean");
        end else begin
            $display("dle_stx_lrc_deframer_unit_tb: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready gaps, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                res_if.ready <= 1'b0;
                gap_left--;
            end else begin
                res_if.ready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every beat against the oldest owed result
    // ------------------------------------------------------------------
    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_beats++;
            case (res_if.kind)
                KIND_GOOD:   n_good++;
                KIND_BADLRC: n_lrc++;
                KIND_BADTRL: n_trl++;
                default:     ;
            endcase
            if (pending_res.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%t: unexpected beat kind %0d data %02h len %0d", $realtime,
                             res_if.kind, res_if.data, res_if.frame_length);
            end else begin
                want_res = pending_res.pop_front();
                if (res_if.kind !== want_res.kind || res_if.data !== want_res.data ||
                    res_if.frame_length !== want_res.frame_length) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%t: beat mismatch: got kind %0d data %02h len %0d",
                                 $realtime, res_if.kind, res_if.data,
                                 res_if.frame_length);
                        $display("    want kind %0d data %02h len %0d",
                                 want_res.kind, want_res.data, want_res.frame_length);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #20ms;
        $display("timeout with %0d beats still owed", pending_res.size());
        $display("dle_stx_lrc_deframer_unit_tb: errors");
        $finish;
    end

endmodule
